// ----- rtl/core/mma_pkg.sv -----
package mma_pkg;

  // Block dimensions
  localparam int CHANNELS    = 4;
  localparam int RING_DEPTH  = 64;
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_REGS    = 4;

  // Field and register widths
  localparam int CH_W      = 2;
  localparam int LOG2_W    = 3;
  localparam int REG_IDX_W = 2;
  localparam int TDATA_W   = 16;
  localparam int TUSER_W   = CH_W;

  // Derived sizes
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int SUM_W      = SAMPLE_BITS + PTR_W;
  localparam int ADDR_W     = $clog2(CHANNELS * RING_DEPTH);
  localparam int RAM_DEPTH  = CHANNELS * RING_DEPTH;
  // largest exponent whose window stays below the ring depth
  localparam int MAX_LOG2   = PTR_W - 1;
  localparam logic [LOG2_W-1:0] RESET_LOG2 = LOG2_W'(4);

  // Output queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  // Saturate a register exponent to the usable range
  function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] r);
    logic [LOG2_W-1:0] lim;
    lim = LOG2_W'(MAX_LOG2);
    return (r > lim) ? lim : r;
  endfunction

  // Configuration write, as seen by the channel logic
  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [LOG2_W-1:0]    data;
  } cfg_wr_t;

  // Item in flight between pointer stage and accumulate stage
  typedef struct packed {
    logic                   valid;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   zero_old;
    logic [LOG2_W-1:0]      shift;
  } issue_t;

  // Finished result headed to the output queue
  typedef struct packed {
    logic                   valid;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] avg;
  } result_t;

endpackage

// ----- rtl/core/multichannel_moving_average_core.sv -----
// Four-channel moving-average filter for 10-bit converter samples.
//
// Input stream (s_*): one transaction carries a sample in s_tdata and its
// channel number in s_tuser. Output stream (m_*): one transaction per input,
// with the channel echoed in m_tuser and the window average in m_tdata.
// Config port: wr_en/wr_index/wr_data write channel window exponents
// (window = 2^exponent samples, exponents above 5 act as 5). A write clears
// that channel's history and sum; write only while the block is idle.
//
// Throughput: one sample per cycle on any channel mix while s_tready is
// high. Each sample does one read of the oldest ring slot and one write of
// the newest slot in the same cycle on the dual-port ring memory; the
// running sum is updated in the following cycle, as the result enters the queue.
// Stalls: results wait in a 3-entry output queue; s_tready drops once the
// queue and the accumulate stage together hold 3 results.
// Reset: synchronous; all windows return to 16 samples, sums and pointers to
// zero. Ring history is masked by per-channel fill counters, so no memory
// clearing pass is needed and input is accepted right after reset.
module multichannel_moving_average_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mma_pkg::TDATA_W-1:0]       s_tdata,   // [9:0] sample, rest zero
  input  logic [mma_pkg::TUSER_W-1:0]       s_tuser,   // [1:0] channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mma_pkg::TDATA_W-1:0]       m_tdata,   // [9:0] average, rest zero
  output logic [mma_pkg::TUSER_W-1:0]       m_tuser,   // [1:0] channel_out
  input  logic                              wr_en,
  input  logic [mma_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [mma_pkg::LOG2_W-1:0]        wr_data
);
  import mma_pkg::*;

  cfg_wr_t                cfg;
  issue_t                 issue;
  result_t                res;
  logic                   accept;
  logic                   can_accept;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] out_avg;

  // Handshake and config bundling
  always_comb begin
    s_tready = can_accept;
    accept   = s_tvalid && can_accept;
    cfg.we   = wr_en;
    cfg.idx  = wr_index;
    cfg.data = wr_data;
    m_tdata  = TDATA_W'(out_avg);
  end

  mma_chan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .ch        (s_tuser[CH_W-1:0]),
    .smp       (s_tdata[SAMPLE_BITS-1:0]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .issue     (issue)
  );

  mma_ring_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mma_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .issue    (issue),
    .old_data (ram_rdata),
    .res      (res)
  );

  mma_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .can_accept (can_accept),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ch     (m_tuser),
    .out_avg    (out_avg)
  );

endmodule

// ----- rtl/core/mma_ring_ram.sv -----
module mma_ring_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mma_chan_ctrl.sv -----
module mma_chan_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  mma_pkg::cfg_wr_t                cfg,
  input  logic                            accept,
  input  logic [mma_pkg::CH_W-1:0]        ch,
  input  logic [mma_pkg::SAMPLE_BITS-1:0] smp,
  output logic                            ram_we,
  output logic [mma_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [mma_pkg::SAMPLE_BITS-1:0] ram_wdata,
  output logic [mma_pkg::ADDR_W-1:0]      ram_raddr,
  output mma_pkg::issue_t                 issue
);
  import mma_pkg::*;

  logic [LOG2_W-1:0] window_log2 [CHANNELS];
  logic [PTR_W-1:0]  lo_ptr      [CHANNELS];
  logic [PTR_W-1:0]  fill        [CHANNELS];

  logic [LOG2_W-1:0] e_cur;
  logic [PTR_W:0]    win;
  logic [PTR_W:0]    hi_sum;
  logic [PTR_W-1:0]  hi_ptr;
  logic [PTR_W-1:0]  lo_cur;
  logic [PTR_W-1:0]  lo_next;
  logic              zero_old;

  // Newest slot sits one window ahead of the oldest slot
  always_comb begin
    e_cur    = eff_log2(window_log2[ch]);
    win      = (PTR_W+1)'(1) << e_cur;
    lo_cur   = lo_ptr[ch];
    hi_sum   = {1'b0, lo_cur} + win;
    hi_ptr   = (hi_sum >= (PTR_W+1)'(RING_DEPTH)) ?
               PTR_W'(hi_sum - (PTR_W+1)'(RING_DEPTH)) : hi_sum[PTR_W-1:0];
    lo_next  = (lo_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : lo_cur + PTR_W'(1);
    // slots not yet refilled since the last clear read as zero
    zero_old = ({1'b0, fill[ch]} < win);
  end

  // Ring addresses: channel base plus pointer
  always_comb begin
    ram_we    = accept;
    ram_wdata = smp;
    ram_waddr = ADDR_W'(ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(hi_ptr);
    ram_raddr = ADDR_W'(ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(lo_cur);
  end

  // Per-channel pointer state and window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        window_log2[i] <= RESET_LOG2;
        lo_ptr[i]      <= '0;
        fill[i]        <= '0;
      end
    end else begin
      if (cfg.we && (32'(cfg.idx) < CHANNELS)) begin
        window_log2[cfg.idx] <= cfg.data;
        lo_ptr[cfg.idx]      <= '0;
        fill[cfg.idx]        <= '0;
      end
      if (accept) begin
        lo_ptr[ch] <= lo_next;
        if (zero_old) begin
          fill[ch] <= fill[ch] + PTR_W'(1);
        end
      end
    end
  end

  // Issue register lines up with the ring read data
  always_ff @(posedge clk) begin
    if (rst) begin
      issue.valid <= 1'b0;
    end else begin
      issue.valid <= accept;
    end
    issue.ch       <= ch;
    issue.smp      <= smp;
    issue.zero_old <= zero_old;
    issue.shift    <= e_cur;
  end

endmodule

// ----- rtl/core/mma_accum.sv -----
module mma_accum (
  input  logic                            clk,
  input  logic                            rst,
  input  mma_pkg::cfg_wr_t                cfg,
  input  mma_pkg::issue_t                 issue,
  input  logic [mma_pkg::SAMPLE_BITS-1:0] old_data,
  output mma_pkg::result_t                res
);
  import mma_pkg::*;

  logic [SUM_W-1:0]       sum [CHANNELS];
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       avg_wide;

  // Drop the oldest sample, add the new one, scale by the window
  always_comb begin
    old_val  = issue.zero_old ? '0 : old_data;
    sum_next = sum[issue.ch] - SUM_W'(old_val) + SUM_W'(issue.smp);
    avg_wide = sum_next >> issue.shift;
    res.valid = issue.valid;
    res.ch    = issue.ch;
    res.avg   = avg_wide[SAMPLE_BITS-1:0];
  end

  // Running sums; a window write clears its channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (cfg.we && (32'(cfg.idx) < CHANNELS)) begin
        sum[cfg.idx] <= '0;
      end
      if (issue.valid) begin
        sum[issue.ch] <= sum_next;
      end
    end
  end

endmodule

// ----- rtl/core/mma_out_fifo.sv -----
module mma_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  mma_pkg::result_t                res,
  output logic                            can_accept,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mma_pkg::CH_W-1:0]        out_ch,
  output logic [mma_pkg::SAMPLE_BITS-1:0] out_avg
);
  import mma_pkg::*;

  logic [CH_W-1:0]        q_ch  [FIFO_DEPTH];
  logic [SAMPLE_BITS-1:0] q_avg [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic                   pop;
  logic [FIFO_CNT_W:0]    committed;

  // Room must cover the result already in the accumulate stage
  always_comb begin
    committed  = {1'b0, count} + (FIFO_CNT_W+1)'(res.valid);
    can_accept = (committed < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    out_valid  = (count != '0);
    out_ch     = q_ch[rd_ptr];
    out_avg    = q_avg[rd_ptr];
    pop        = out_valid && out_ready;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (res.valid) begin
      q_ch[wr_ptr]  <= res.ch;
      q_avg[wr_ptr] <= res.avg;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (res.valid && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (!res.valid && pop) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/mma_checker.sv -----
module mma_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [mma_pkg::TDATA_W-1:0]   s_tdata,
  input logic [mma_pkg::TUSER_W-1:0]   s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mma_pkg::TDATA_W-1:0]   m_tdata,
  input logic [mma_pkg::TUSER_W-1:0]   m_tuser,
  input logic                          wr_en,
  input logic [mma_pkg::REG_IDX_W-1:0] wr_index,
  input logic [mma_pkg::LOG2_W-1:0]    wr_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // Reset empties the output queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Every accepted sample shows a result once it has passed the issue register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("result missing two cycles after input");

  // An output appearing from empty comes from an earlier accepted input
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) && !$past(rst) && !$past(rst, 2) |->
      $past(s_tvalid && s_tready, 2))
    else $error("result without an input");

endmodule

bind multichannel_moving_average_core mma_checker u_mma_checker (.*);
